[hw/rtl/rtg_pkg.sv]
// rtg_pkg: shared widths, types and helpers for the pinhole camera ray generator.
// No dependencies; imported by every module of the block.
package rtg_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int FRAC_BITS = 17;

    localparam int PIX_W     = 12;
    localparam int DIM_W     = 13;
    localparam int VEC_W     = 21;
    localparam int DIR_W     = 18;
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 120;

    localparam int PROD_W    = VEC_W + DIR_W + 1;
    localparam int TERM_W    = PROD_W - FRAC_BITS;
    localparam int DIFF_W    = 24;
    localparam int MAG_W     = 23;
    localparam int K_W       = 5;
    localparam int SQR_W     = 2 * MAG_W;
    localparam int DIR_SHIFT = 24;
    localparam int DIR_ONE   = 65536;

    // pipelined restoring divider
    localparam int DIV_N_W   = MAG_W + DIR_SHIFT;
    localparam int DIV_D_W   = 31;
    localparam int DIV_Q_W   = 18;
    localparam int DIV_C_W   = DIV_D_W + DIV_Q_W - 1;

    // pipelined integer square root
    localparam int SQ_N_W    = SQR_W + 16;
    localparam int SQ_R_W    = SQ_N_W / 2;

    // side data held alongside the root
    localparam int SIDE_LEN  = SQ_R_W + 3;

    // stage count from accept to output register
    localparam int LAT       = 1 + DIV_Q_W + 8 + SQ_R_W + 1 + DIV_Q_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POSITION = 3'd0,
        REG_CORNER   = 3'd1,
        REG_SPAN_H   = 3'd2,
        REG_SPAN_V   = 3'd3,
        REG_WIDTH    = 3'd4,
        REG_HEIGHT   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  zero;
    } side_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } flag_t;

    // image size minus one, after clamping the size to [2, MAX_DIM]
    function automatic logic [PIX_W-1:0] dim_m1(input logic [DIM_W-1:0] d);
        logic [PIX_W-1:0] r;
        if (d < DIM_W'(2))
        begin
            r = PIX_W'(1);
        end
        else if (d > DIM_W'(MAX_DIM))
        begin
            r = PIX_W'(MAX_DIM - 1);
        end
        else
        begin
            r = PIX_W'(d - DIM_W'(1));
        end
        return r;
    endfunction

endpackage

[hw/rtl/rtg_div.sv]
// rtg_div: pipelined restoring divider, one quotient bit per register stage.
// Depends on rtg_pkg. Needs dividend < divisor * 2^DIV_Q_W.
module rtg_div (
    input  logic                         clk,
    input  logic                         en,
    input  logic [rtg_pkg::DIV_N_W-1:0]  dividend,
    input  logic [rtg_pkg::DIV_D_W-1:0]  divisor,
    output logic [rtg_pkg::DIV_Q_W-1:0]  quotient
);
    import rtg_pkg::*;

    logic [DIV_N_W-1:0] rem_in  [0:DIV_Q_W];
    logic [DIV_D_W-1:0] dvs_in  [0:DIV_Q_W];
    logic [DIV_Q_W-1:0] quo_in  [0:DIV_Q_W];

    assign rem_in[0] = dividend;
    assign dvs_in[0] = divisor;
    assign quo_in[0] = '0;

    for (genvar j = 0; j < DIV_Q_W; j++)
    begin : g_stage
        localparam int B = DIV_Q_W - 1 - j;
        logic [DIV_C_W-1:0] sh;
        logic [DIV_C_W-1:0] rx;
        logic [DIV_N_W-1:0] rem_reg, rem_next;
        logic [DIV_D_W-1:0] dvs_reg;
        logic [DIV_Q_W-1:0] quo_reg, quo_next;

        always_comb
        begin
            sh = DIV_C_W'(dvs_in[j]) << B;
            rx = DIV_C_W'(rem_in[j]);
            if (rx >= sh)
            begin
                rem_next = DIV_N_W'(rx - sh);
                quo_next = quo_in[j] | (DIV_Q_W'(1) << B);
            end
            else
            begin
                rem_next = rem_in[j];
                quo_next = quo_in[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= rem_next;
                dvs_reg <= dvs_in[j];
                quo_reg <= quo_next;
            end
        end

        assign rem_in[j+1] = rem_reg;
        assign dvs_in[j+1] = dvs_reg;
        assign quo_in[j+1] = quo_reg;
    end

    assign quotient = quo_in[DIV_Q_W];

endmodule

[hw/rtl/rtg_sqrt.sv]
// rtg_sqrt: pipelined integer square root, one result bit per register stage.
// Depends on rtg_pkg.
module rtg_sqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [rtg_pkg::SQ_N_W-1:0]  radicand,
    output logic [rtg_pkg::SQ_R_W-1:0]  root
);
    import rtg_pkg::*;

    logic [SQ_N_W-1:0] rem_in [0:SQ_R_W];
    logic [SQ_N_W-1:0] res_in [0:SQ_R_W];

    assign rem_in[0] = radicand;
    assign res_in[0] = '0;

    for (genvar j = 0; j < SQ_R_W; j++)
    begin : g_stage
        localparam int P = 2 * (SQ_R_W - 1 - j);
        logic [SQ_N_W:0]   trial;
        logic [SQ_N_W-1:0] rem_reg, rem_next;
        logic [SQ_N_W-1:0] res_reg, res_next;

        always_comb
        begin
            trial = (SQ_N_W + 1)'(res_in[j]) + ((SQ_N_W + 1)'(1) << P);
            if ((SQ_N_W + 1)'(rem_in[j]) >= trial)
            begin
                rem_next = SQ_N_W'((SQ_N_W + 1)'(rem_in[j]) - trial);
                res_next = (res_in[j] >> 1) + (SQ_N_W'(1) << P);
            end
            else
            begin
                rem_next = rem_in[j];
                res_next = res_in[j] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= rem_next;
                res_reg <= res_next;
            end
        end

        assign rem_in[j+1] = rem_reg;
        assign res_in[j+1] = res_reg;
    end

    assign root = res_in[SQ_R_W][SQ_R_W-1:0];

endmodule

[hw/rtl/pinhole_camera_ray_generator.sv]
// Throughput one word per clock while no output word waits unaccepted.
// The pipeline runs through the 18-stage u/v and direction dividers and the 31-stage square root.
// The whole pipeline holds while an output word waits unaccepted.
// Reset (rst_n, asynchronous, active low) empties the pipeline, clears the vectors
// and sets the image size to 2 x 2.
// Depends on rtg_pkg, rtg_div, rtg_sqrt.
module pinhole_camera_ray_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [11:0] pixel_x, [23:12] pixel_y
    input  logic [rtg_pkg::IN_W-1:0]       s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [20:0] origin_x, [41:21] origin_y, [62:42] origin_z,
    // [80:63] dir_x, [98:81] dir_y, [116:99] dir_z, [119:117] zero
    output logic [rtg_pkg::OUT_W-1:0]      m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rtg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtg_pkg::CFG_W-1:0]      cfg_data
);
    import rtg_pkg::*;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] pos_reg, corner_reg, span_h_reg, span_v_reg;
    logic [DIM_W-1:0] width_reg, height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            corner_reg <= '0;
            span_h_reg <= '0;
            span_v_reg <= '0;
            width_reg  <= DIM_W'(2);
            height_reg <= DIM_W'(2);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_POSITION: pos_reg    <= cfg_data;
                REG_CORNER:   corner_reg <= cfg_data;
                REG_SPAN_H:   span_h_reg <= cfg_data;
                REG_SPAN_V:   span_v_reg <= cfg_data;
                REG_WIDTH:    width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT:   height_reg <= cfg_data[DIM_W-1:0];
                default:      ; // unknown index: write dropped
            endcase
        end
    end

    // vector components, x in the low bits
    logic signed [VEC_W-1:0] pos_c [3], corner_c [3], span_h_c [3], span_v_c [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pos_c[i]    = $signed(pos_reg[VEC_W*i +: VEC_W]);
            corner_c[i] = $signed(corner_reg[VEC_W*i +: VEC_W]);
            span_h_c[i] = $signed(span_h_reg[VEC_W*i +: VEC_W]);
            span_v_c[i] = $signed(span_v_reg[VEC_W*i +: VEC_W]);
        end
    end

    // ---------------- pipeline control ----------------
    // Single advance enable: every stage moves unless the output word is stuck.
    logic           en;
    logic           in_acc;
    logic [LAT-1:0] vld_reg;

    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign in_acc        = s_axis_tvalid && en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_acc};
        end
    end

    // ---------------- stage 1: saturate pixel, build u/v dividends ----------------
    logic [PIX_W-1:0]   wm1, hm1, px, py, px_sat, py_sat;
    logic [DIV_N_W-1:0] u_dvd_reg, u_dvd_next, v_dvd_reg, v_dvd_next;

    always_comb
    begin
        wm1    = dim_m1(width_reg);
        hm1    = dim_m1(height_reg);
        px     = s_axis_tdata[PIX_W-1:0];
        py     = s_axis_tdata[2*PIX_W-1:PIX_W];
        px_sat = (px > wm1) ? wm1 : px;
        py_sat = (py > hm1) ? hm1 : py;
        // rounded to nearest: (n * 2^F + floor(d/2)) / d
        u_dvd_next = (DIV_N_W'(px_sat) << FRAC_BITS) + DIV_N_W'(wm1 >> 1);
        v_dvd_next = (DIV_N_W'(hm1 - py_sat) << FRAC_BITS) + DIV_N_W'(hm1 >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_dvd_reg <= u_dvd_next;
            v_dvd_reg <= v_dvd_next;
        end
    end

    // ---------------- stages 2-19: u and v ----------------
    logic [DIV_Q_W-1:0] u_q, v_q;

    rtg_div u_div_u (
        .clk      (clk),
        .en       (en),
        .dividend (u_dvd_reg),
        .divisor  (DIV_D_W'(wm1)),
        .quotient (u_q)
    );

    rtg_div u_div_v (
        .clk      (clk),
        .en       (en),
        .dividend (v_dvd_reg),
        .divisor  (DIV_D_W'(hm1)),
        .quotient (v_q)
    );

    // ---------------- stages 20-23: target, difference, magnitude ----------------
    logic signed [PROD_W-1:0] ph_reg [3], pv_reg [3];
    logic signed [TERM_W-1:0] th_reg [3], tv_reg [3];
    logic signed [DIFF_W-1:0] d_reg  [3];
    logic [MAG_W-1:0]         mag_reg [3];
    logic [2:0]               neg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ph_reg[i]  <= PROD_W'(span_h_c[i]) * PROD_W'($signed({1'b0, u_q}));
                pv_reg[i]  <= PROD_W'(span_v_c[i]) * PROD_W'($signed({1'b0, v_q}));
                // ties toward plus infinity
                th_reg[i]  <= TERM_W'((ph_reg[i] + ROUND_HALF) >>> FRAC_BITS);
                tv_reg[i]  <= TERM_W'((pv_reg[i] + ROUND_HALF) >>> FRAC_BITS);
                d_reg[i]   <= DIFF_W'(corner_c[i]) + DIFF_W'(th_reg[i])
                            + DIFF_W'(tv_reg[i]) - DIFF_W'(pos_c[i]);
                neg_reg[i] <= d_reg[i][DIFF_W-1];
                mag_reg[i] <= d_reg[i][DIFF_W-1] ? MAG_W'(-d_reg[i]) : MAG_W'(d_reg[i]);
            end
        end
    end

    // ---------------- stage 24: largest magnitude, normalising shift ----------------
    logic [MAG_W-1:0] m_max;
    logic [K_W-1:0]   msb_pos, k_next, k_reg;
    logic [MAG_W-1:0] mag24_reg [3];
    flag_t            fl24_reg;

    always_comb
    begin
        m_max = mag_reg[0];
        if (mag_reg[1] > m_max)
        begin
            m_max = mag_reg[1];
        end
        if (mag_reg[2] > m_max)
        begin
            m_max = mag_reg[2];
        end
        msb_pos = '0;
        for (int b = 0; b < MAG_W - 2; b++)
        begin
            if (m_max[b])
            begin
                msb_pos = K_W'(b);
            end
        end
        // shift until the largest reaches 2^21
        if (m_max[MAG_W-1] || m_max[MAG_W-2])
        begin
            k_next = '0;
        end
        else
        begin
            k_next = K_W'(MAG_W - 2) - msb_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag24_reg[i] <= mag_reg[i];
            end
            k_reg         <= k_next;
            fl24_reg.neg  <= neg_reg;
            fl24_reg.zero <= (m_max == '0);
        end
    end

    // ---------------- stages 25-58: shifted magnitudes ride beside the root ----------------
    side_t side_reg [SIDE_LEN];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                side_reg[0].mag[i] <= mag24_reg[i] << k_reg;
            end
            side_reg[0].neg  <= fl24_reg.neg;
            side_reg[0].zero <= fl24_reg.zero;
            for (int j = 1; j < SIDE_LEN; j++)
            begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // stages 26-27: sum of squares
    logic [SQR_W-1:0]  sq_reg [3];
    logic [SQ_N_W-1:0] rad_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= SQR_W'(side_reg[0].mag[i]) * SQR_W'(side_reg[0].mag[i]);
            end
            rad_reg <= {sq_reg[0] + sq_reg[1] + sq_reg[2], 16'b0};
        end
    end

    // stages 28-58: root
    logic [SQ_R_W-1:0] root;

    rtg_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (rad_reg),
        .root     (root)
    );

    // ---------------- stage 59: direction dividends ----------------
    logic [DIV_N_W-1:0] dd_reg [3];
    logic [SQ_R_W-1:0]  root_reg;
    flag_t              fl59_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dd_reg[i] <= (DIV_N_W'(side_reg[SIDE_LEN-1].mag[i]) << DIR_SHIFT)
                           + DIV_N_W'(root >> 1);
            end
            root_reg      <= root;
            fl59_reg.neg  <= side_reg[SIDE_LEN-1].neg;
            fl59_reg.zero <= side_reg[SIDE_LEN-1].zero;
        end
    end

    // ---------------- stages 60-77: three direction dividers ----------------
    logic [DIV_Q_W-1:0] r_q [3];
    flag_t              fl_reg [DIV_Q_W];

    for (genvar i = 0; i < 3; i++)
    begin : g_dir
        rtg_div u_div_dir (
            .clk      (clk),
            .en       (en),
            .dividend (dd_reg[i]),
            .divisor  (root_reg),
            .quotient (r_q[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fl_reg[0] <= fl59_reg;
            for (int j = 1; j < DIV_Q_W; j++)
            begin
                fl_reg[j] <= fl_reg[j-1];
            end
        end
    end

    // ---------------- stage 78: cap, sign, output register ----------------
    logic [DIR_W-1:0] dir_reg [3], dir_next [3], cap [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cap[i] = (r_q[i] > DIR_W'(DIR_ONE)) ? DIR_W'(DIR_ONE) : r_q[i];
            if (fl_reg[DIV_Q_W-1].zero)
            begin
                dir_next[i] = '0;   // target on the camera: no direction
            end
            else if (fl_reg[DIV_Q_W-1].neg[i])
            begin
                dir_next[i] = -cap[i];
            end
            else
            begin
                dir_next[i] = cap[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dir_reg[i] <= dir_next[i];
            end
        end
    end

    // origin comes straight from the register; the user must hold it while words are in flight
    assign m_axis_tdata = {3'b000, dir_reg[2], dir_reg[1], dir_reg[0], pos_reg};

endmodule

[hw/rtl/rtg_checker.sv]
// rtg_checker: port-level assertions for the ray generator, bound to the top level.
// Depends on rtg_pkg and pinhole_camera_ray_generator.
module rtg_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [rtg_pkg::OUT_W-1:0]      m_axis_tdata
);
    import rtg_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // input only backs up behind a stuck output word
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with free output");

    // direction components stay within unit range
    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[80:63]) <= 18'sd65536)
            && ($signed(m_axis_tdata[80:63]) >= -18'sd65536)
            && ($signed(m_axis_tdata[98:81]) <= 18'sd65536)
            && ($signed(m_axis_tdata[98:81]) >= -18'sd65536)
            && ($signed(m_axis_tdata[116:99]) <= 18'sd65536)
            && ($signed(m_axis_tdata[116:99]) >= -18'sd65536))
        else $error("direction out of range");

    // padding bits are zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_W-1:117] == '0)
        else $error("padding bits set");

endmodule

bind pinhole_camera_ray_generator rtg_checker u_rtg_checker (.*);
